### hdl/mlt_pkg.sv
// Shared types and codes for the MAC learning table.
package mlt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int DEF_PORT_BITS   = 6;
    localparam int DEF_TIME_BITS   = 32;
    localparam int CFG_W           = 32;
    localparam int VLAN_W          = 12;
    localparam int MAC_W           = 48;
    localparam int STATUS_W        = 4;
    localparam logic [CFG_W-1:0] AGEING_RESET = CFG_W'(300);

    typedef enum logic [2:0] {
        K_LEARN        = 3'd0,
        K_LEARN_STATIC = 3'd1,
        K_LOOKUP       = 3'd2,
        K_REMOVE       = 3'd3,
        K_REM_PORT     = 3'd4,
        K_REM_VLAN     = 3'd5,
        K_CLEAR        = 3'd6,
        K_EXPIRE       = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_LEARNED      = 4'd0,
        ST_MOVED        = 4'd1,
        ST_UNCHANGED    = 4'd2,
        ST_FULL         = 4'd3,
        ST_HIT          = 4'd4,
        ST_MISS         = 4'd5,
        ST_REMOVED      = 4'd6,
        ST_NOT_FOUND    = 4'd7,
        ST_DONE         = 4'd8,
        ST_EXPIRED      = 4'd9,
        ST_NONE_EXPIRED = 4'd10
    } status_t;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_RUN  = 1'b1
    } fsm_t;

    // Control broadcast to every cell
    typedef struct packed {
        kind_t kind;
        logic  fire;
        logic  any_hit;
    } cell_ctl_t;

endpackage

### hdl/mlt_cell.sv
// One table slot: entry storage, key compare and priority chain links.
module mlt_cell #(
    parameter int PORT_BITS = mlt_pkg::DEF_PORT_BITS,
    parameter int TIME_BITS = mlt_pkg::DEF_TIME_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  mlt_pkg::cell_ctl_t          ctl,
    input  logic [mlt_pkg::VLAN_W-1:0]  cmd_vlan,
    input  logic [mlt_pkg::MAC_W-1:0]   cmd_mac,
    input  logic [PORT_BITS-1:0]        cmd_port,
    input  logic [TIME_BITS-1:0]        cmd_now,
    input  logic [TIME_BITS-1:0]        cmd_expiry,
    input  logic                        free_in,
    input  logic                        aged1_in,
    input  logic                        aged2_in,
    output logic                        free_out,
    output logic                        aged1_out,
    output logic                        aged2_out,
    output logic                        key_hit,
    output logic                        clr_hit,
    output logic [mlt_pkg::VLAN_W-1:0]  view_vlan,
    output logic [mlt_pkg::MAC_W-1:0]   view_mac,
    output logic [PORT_BITS-1:0]        view_port,
    output logic                        view_static,
    output logic                        view_aged
);
    import mlt_pkg::*;

    logic                 valid_reg, valid_next;
    logic                 static_reg, static_next;
    logic [VLAN_W-1:0]    vlan_reg, vlan_next;
    logic [MAC_W-1:0]     mac_reg, mac_next;
    logic [PORT_BITS-1:0] port_reg, port_next;
    logic [TIME_BITS-1:0] expiry_reg, expiry_next;

    logic aged, free_first, aged_first, pick;

    // Compare against the broadcast command
    assign key_hit    = valid_reg && (vlan_reg == cmd_vlan) && (mac_reg == cmd_mac);
    assign aged       = valid_reg && !static_reg && (cmd_now >= expiry_reg);
    assign free_first = !valid_reg && !free_in;
    assign aged_first = aged && !aged1_in;
    assign clr_hit    = valid_reg && ((ctl.kind == K_CLEAR) ||
                        ((ctl.kind == K_REM_PORT) && (port_reg == cmd_port)) ||
                        ((ctl.kind == K_REM_VLAN) && (vlan_reg == cmd_vlan)));

    // Pass priority chains to the next cell
    assign free_out  = free_in || !valid_reg;
    assign aged1_out = aged1_in || aged;
    assign aged2_out = aged2_in || (aged1_in && aged);

    // Offer the selected entry to the output mux
    assign pick        = (ctl.kind == K_EXPIRE) ? aged_first : key_hit;
    assign view_vlan   = pick ? vlan_reg : '0;
    assign view_mac    = pick ? mac_reg : '0;
    assign view_port   = pick ? port_reg : '0;
    assign view_static = pick && static_reg;
    assign view_aged   = pick && aged;

    // Apply the command to this slot
    always_comb begin
        valid_next  = valid_reg;
        static_next = static_reg;
        vlan_next   = vlan_reg;
        mac_next    = mac_reg;
        port_next   = port_reg;
        expiry_next = expiry_reg;
        if (ctl.fire) begin
            unique case (ctl.kind)
                K_LEARN: begin
                    if (ctl.any_hit) begin
                        if (key_hit && !static_reg) begin
                            port_next   = cmd_port;
                            expiry_next = cmd_expiry;
                        end
                    end else if (free_first) begin
                        valid_next  = 1'b1;
                        static_next = 1'b0;
                        vlan_next   = cmd_vlan;
                        mac_next    = cmd_mac;
                        port_next   = cmd_port;
                        expiry_next = cmd_expiry;
                    end
                end
                K_LEARN_STATIC: begin
                    if (ctl.any_hit ? key_hit : free_first) begin
                        valid_next  = 1'b1;
                        static_next = 1'b1;
                        vlan_next   = cmd_vlan;
                        mac_next    = cmd_mac;
                        port_next   = cmd_port;
                        expiry_next = cmd_now;
                    end
                end
                K_LOOKUP: ;
                K_REMOVE: begin
                    if (key_hit) valid_next = 1'b0;
                end
                K_REM_PORT, K_REM_VLAN, K_CLEAR: begin
                    if (clr_hit) valid_next = 1'b0;
                end
                K_EXPIRE: begin
                    if (aged_first) valid_next = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        static_reg <= static_next;
        vlan_reg   <= vlan_next;
        mac_reg    <= mac_next;
        port_reg   <= port_next;
        expiry_reg <= expiry_next;
    end

endmodule

### hdl/mac_learning_table.sv
// Top level of the MAC learning table: command register, cell row and result register.
//
// Usage: items enter on s_* (valid/ready) and carry a kind plus key, port and time.
// Results leave on m_* (valid/ready); m_last marks the final result of an item.
// ageing_time is written through cfg_wr_en/cfg_wr_data while the block is idle.
// Every slot is a cell in a row; all cells compare the key in parallel and a
// free-slot chain and an aged-entry chain run through the row to pick the
// lowest slot. The cell row is the limiting path.
// An item is taken into the command register, and its result is loaded into the
// output register once that register is free. remove_expired gives its k aged
// entries one entry per cycle while the receiver is ready.
// s_ready is high only while no item is in progress.
// A stalled receiver holds the result register and the item in progress;
// no table state changes until the result can be loaded.
// Reset empties the table at once (valid bits cleared) and sets
// ageing_time to 300; no clearing pass is needed.
module mac_learning_table #(
    parameter int TABLE_DEPTH = mlt_pkg::DEF_TABLE_DEPTH,
    parameter int PORT_BITS   = mlt_pkg::DEF_PORT_BITS,
    parameter int TIME_BITS   = mlt_pkg::DEF_TIME_BITS,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mlt_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [2:0]                  s_kind,
    input  logic [mlt_pkg::VLAN_W-1:0]  s_vlan,
    input  logic [mlt_pkg::MAC_W-1:0]   s_mac,
    input  logic [PORT_BITS-1:0]        s_port,
    input  logic [TIME_BITS-1:0]        s_now,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mlt_pkg::STATUS_W-1:0] m_status,
    output logic [mlt_pkg::VLAN_W-1:0]  m_out_vlan,
    output logic [mlt_pkg::MAC_W-1:0]   m_out_mac,
    output logic [PORT_BITS-1:0]        m_out_port,
    output logic                        m_out_static,
    output logic [CNT_W-1:0]            m_removed_count,
    output logic                        m_last
);
    import mlt_pkg::*;

    fsm_t state_reg, state_next;

    logic [CFG_W-1:0]     ageing_reg;
    kind_t                kind_reg;
    logic [VLAN_W-1:0]    vlan_reg;
    logic [MAC_W-1:0]     mac_reg;
    logic [PORT_BITS-1:0] port_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] expiry;

    logic                 m_valid_reg, m_valid_next;
    status_t              status_reg, status_next;
    logic [VLAN_W-1:0]    ovlan_reg, ovlan_next;
    logic [MAC_W-1:0]     omac_reg, omac_next;
    logic [PORT_BITS-1:0] oport_reg, oport_next;
    logic                 ostatic_reg, ostatic_next;
    logic [CNT_W-1:0]     ocnt_reg, ocnt_next;
    logic                 olast_reg, olast_next;

    logic                 fire, out_free, any_hit, more_aged;
    cell_ctl_t            ctl;

    logic [TABLE_DEPTH:0]   free_c, aged1_c, aged2_c;
    logic [TABLE_DEPTH-1:0] hit_v, clr_v, stat_v, agd_v;
    logic [VLAN_W-1:0]      vview [TABLE_DEPTH];
    logic [MAC_W-1:0]       mview [TABLE_DEPTH];
    logic [PORT_BITS-1:0]   pview [TABLE_DEPTH];
    logic [VLAN_W-1:0]      sel_vlan;
    logic [MAC_W-1:0]       sel_mac;
    logic [PORT_BITS-1:0]   sel_port;

    // Expiry of a dynamic learn, wrapping at the time width
    assign expiry = now_reg + TIME_BITS'(ageing_reg);

    assign out_free  = !m_valid_reg || m_ready;
    assign fire      = (state_reg == FSM_RUN) && out_free;
    assign any_hit   = |hit_v;
    assign more_aged = aged2_c[TABLE_DEPTH];

    assign ctl.kind    = kind_reg;
    assign ctl.fire    = fire;
    assign ctl.any_hit = any_hit;

    assign free_c[0]  = 1'b0;
    assign aged1_c[0] = 1'b0;
    assign aged2_c[0] = 1'b0;

    // Row of slot cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        mlt_cell #(
            .PORT_BITS (PORT_BITS),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .cmd_vlan    (vlan_reg),
            .cmd_mac     (mac_reg),
            .cmd_port    (port_reg),
            .cmd_now     (now_reg),
            .cmd_expiry  (expiry),
            .free_in     (free_c[i]),
            .aged1_in    (aged1_c[i]),
            .aged2_in    (aged2_c[i]),
            .free_out    (free_c[i+1]),
            .aged1_out   (aged1_c[i+1]),
            .aged2_out   (aged2_c[i+1]),
            .key_hit     (hit_v[i]),
            .clr_hit     (clr_v[i]),
            .view_vlan   (vview[i]),
            .view_mac    (mview[i]),
            .view_port   (pview[i]),
            .view_static (stat_v[i]),
            .view_aged   (agd_v[i])
        );
    end

    // Merge the one selected entry
    always_comb begin
        sel_vlan = '0;
        sel_mac  = '0;
        sel_port = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            sel_vlan = sel_vlan | vview[i];
            sel_mac  = sel_mac | mview[i];
            sel_port = sel_port | pview[i];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (s_valid) state_next = FSM_RUN;
            FSM_RUN: begin
                if (fire && !((kind_reg == K_EXPIRE) && more_aged)) state_next = FSM_IDLE;
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // Build the result
    always_comb begin
        s_ready      = (state_reg == FSM_IDLE);
        m_valid_next = m_valid_reg && !m_ready;
        status_next  = status_reg;
        ovlan_next   = ovlan_reg;
        omac_next    = omac_reg;
        oport_next   = oport_reg;
        ostatic_next = ostatic_reg;
        ocnt_next    = ocnt_reg;
        olast_next   = olast_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            ovlan_next   = '0;
            omac_next    = '0;
            oport_next   = '0;
            ostatic_next = 1'b0;
            ocnt_next    = '0;
            olast_next   = 1'b1;
            unique case (kind_reg)
                K_LEARN: begin
                    if (any_hit) begin
                        status_next = (|stat_v || (sel_port == port_reg)) ?
                                      ST_UNCHANGED : ST_MOVED;
                    end else begin
                        status_next = free_c[TABLE_DEPTH] ? ST_LEARNED : ST_FULL;
                    end
                end
                K_LEARN_STATIC: begin
                    status_next = (any_hit || free_c[TABLE_DEPTH]) ? ST_DONE : ST_FULL;
                end
                K_LOOKUP: begin
                    if (any_hit && !(|agd_v)) begin
                        status_next  = ST_HIT;
                        ovlan_next   = sel_vlan;
                        omac_next    = sel_mac;
                        oport_next   = sel_port;
                        ostatic_next = |stat_v;
                    end else begin
                        status_next = ST_MISS;
                    end
                end
                K_REMOVE: status_next = any_hit ? ST_REMOVED : ST_NOT_FOUND;
                K_REM_PORT, K_REM_VLAN, K_CLEAR: begin
                    status_next = ST_DONE;
                    ocnt_next   = CNT_W'($countones(clr_v));
                end
                K_EXPIRE: begin
                    if (aged1_c[TABLE_DEPTH]) begin
                        status_next  = ST_EXPIRED;
                        ovlan_next   = sel_vlan;
                        omac_next    = sel_mac;
                        oport_next   = sel_port;
                        ostatic_next = |stat_v;
                        olast_next   = !more_aged;
                    end else begin
                        status_next = ST_NONE_EXPIRED;
                    end
                end
                default: status_next = ST_NONE_EXPIRED;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
            ageing_reg  <= AGEING_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) ageing_reg <= cfg_wr_data;
        end
    end

    // Command and result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= kind_t'(s_kind);
            vlan_reg <= s_vlan;
            mac_reg  <= s_mac;
            port_reg <= s_port;
            now_reg  <= s_now;
        end
        status_reg  <= status_next;
        ovlan_reg   <= ovlan_next;
        omac_reg    <= omac_next;
        oport_reg   <= oport_next;
        ostatic_reg <= ostatic_next;
        ocnt_reg    <= ocnt_next;
        olast_reg   <= olast_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_out_vlan      = ovlan_reg;
    assign m_out_mac       = omac_reg;
    assign m_out_port      = oport_reg;
    assign m_out_static    = ostatic_reg;
    assign m_removed_count = ocnt_reg;
    assign m_last          = olast_reg;

endmodule

### hdl/mlt_checker.sv
// Port-level checks for the MAC learning table, bound to the top level.
module mlt_checker #(
    parameter int CNT_W = 7
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [mlt_pkg::STATUS_W-1:0] m_status,
    input logic [CNT_W-1:0]             m_removed_count,
    input logic                         m_out_static,
    input logic                         m_last
);
    import mlt_pkg::*;

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    // Only expired entries may leave a run without last
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == ST_EXPIRED)
        else $error("non-final result on a single-result kind");

    // A count comes only with done
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_DONE |-> m_removed_count == '0)
        else $error("removed count on wrong status");

    // An expired entry is never static
    a_exp_dyn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EXPIRED |-> !m_out_static)
        else $error("static entry reported as expired");

    // No item is taken while a run of expired entries is still going
    a_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last && m_status == ST_EXPIRED |-> !s_ready)
        else $error("input taken during expired run");

endmodule

bind mac_learning_table mlt_checker #(
    .CNT_W (CNT_W)
) u_mlt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_removed_count (m_removed_count),
    .m_out_static    (m_out_static),
    .m_last          (m_last)
);

### sim/tb_mac_learning_table.sv
// Self-checking testbench for the MAC learning table: forwarding-table predictor and scoreboard.
module tb_mac_learning_table;
    timeunit 1ns;
    timeprecision 1ps;
    import mlt_pkg::*;

    localparam int DEPTH = 64;
    localparam int PB = 6;
    localparam int TB = 32;
    localparam int CW = 7;
    localparam int HOLD_CYCLES = 300;
    localparam longint LIMIT = 2000000;

    typedef struct {
        status_t           status;
        logic [VLAN_W-1:0] vlan;
        logic [MAC_W-1:0]  mac;
        logic [PB-1:0]     port;
        logic              stat;
        logic [CW-1:0]     cnt;
        logic              last;
    } fwd_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [2:0] s_kind = '0;
    logic [VLAN_W-1:0] s_vlan = '0;
    logic [MAC_W-1:0] s_mac = '0;
    logic [PB-1:0] s_port = '0;
    logic [TB-1:0] s_now = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [VLAN_W-1:0] m_out_vlan;
    logic [MAC_W-1:0] m_out_mac;
    logic [PB-1:0] m_out_port;
    logic m_out_static;
    logic [CW-1:0] m_removed_count;
    logic m_last;

    mac_learning_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_vlan(s_vlan),
        .s_mac(s_mac), .s_port(s_port), .s_now(s_now),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_out_vlan(m_out_vlan), .m_out_mac(m_out_mac), .m_out_port(m_out_port),
        .m_out_static(m_out_static), .m_removed_count(m_removed_count), .m_last(m_last)
    );

    // Predictor copy of the table
    logic [CFG_W-1:0]  age_time;
    logic              tv [DEPTH];
    logic              tst [DEPTH];
    logic [VLAN_W-1:0] tvl [DEPTH];
    logic [MAC_W-1:0]  tmc [DEPTH];
    logic [PB-1:0]     tpt [DEPTH];
    logic [TB-1:0]     texp [DEPTH];

    fwd_result_t expected_results[$];
    int errors = 0;
    int mismatches = 0;
    longint cycles = 0;
    bit rx_idle_en = 1'b1;
    bit tx_idle_en = 1'b1;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_off = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void push_result(status_t st, int slot, logic [CW-1:0] cnt, logic lst);
        fwd_result_t r;
        r.status = st;
        r.vlan = '0; r.mac = '0; r.port = '0; r.stat = 1'b0;
        if (slot >= 0) begin
            r.vlan = tvl[slot]; r.mac = tmc[slot]; r.port = tpt[slot]; r.stat = tst[slot];
        end
        r.cnt = cnt;
        r.last = lst;
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic int find_key(logic [VLAN_W-1:0] v, logic [MAC_W-1:0] m);
        for (int i = 0; i < DEPTH; i++)
            if (tv[i] && tvl[i] == v && tmc[i] == m) return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < DEPTH; i++)
            if (!tv[i]) return i;
        return -1;
    endfunction

    function automatic bit is_aged(int i, logic [TB-1:0] now);
        return !tst[i] && now >= texp[i];
    endfunction

    // Advance the predicted table by one item and queue its results
    function automatic void predict_table(kind_t k, logic [VLAN_W-1:0] v, logic [MAC_W-1:0] m,
                                          logic [PB-1:0] p, logic [TB-1:0] now);
        int s;
        int n;
        int j;
        logic [CW-1:0] cnt;
        cnt = '0;
        n = 0;
        j = 0;
        unique case (k)
            K_LEARN: begin
                s = find_key(v, m);
                if (s < 0) begin
                    s = first_free();
                    if (s < 0) push_result(ST_FULL, -1, '0, 1'b1);
                    else begin
                        tv[s] = 1; tst[s] = 0; tvl[s] = v; tmc[s] = m; tpt[s] = p;
                        texp[s] = now + age_time;
                        push_result(ST_LEARNED, -1, '0, 1'b1);
                    end
                end else if (tst[s]) begin
                    push_result(ST_UNCHANGED, -1, '0, 1'b1);
                end else begin
                    push_result(tpt[s] != p ? ST_MOVED : ST_UNCHANGED, -1, '0, 1'b1);
                    tpt[s] = p;
                    texp[s] = now + age_time;
                end
            end
            K_LEARN_STATIC: begin
                s = find_key(v, m);
                if (s < 0) s = first_free();
                if (s < 0) push_result(ST_FULL, -1, '0, 1'b1);
                else begin
                    tv[s] = 1; tst[s] = 1; tvl[s] = v; tmc[s] = m; tpt[s] = p; texp[s] = now;
                    push_result(ST_DONE, -1, '0, 1'b1);
                end
            end
            K_LOOKUP: begin
                s = find_key(v, m);
                if (s < 0 || is_aged(s, now)) push_result(ST_MISS, -1, '0, 1'b1);
                else push_result(ST_HIT, s, '0, 1'b1);
            end
            K_REMOVE: begin
                s = find_key(v, m);
                if (s < 0) push_result(ST_NOT_FOUND, -1, '0, 1'b1);
                else begin
                    tv[s] = 0;
                    push_result(ST_REMOVED, -1, '0, 1'b1);
                end
            end
            K_REM_PORT, K_REM_VLAN, K_CLEAR: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tv[i] && (k == K_CLEAR || (k == K_REM_PORT && tpt[i] == p) ||
                                  (k == K_REM_VLAN && tvl[i] == v))) begin
                        tv[i] = 0;
                        cnt++;
                    end
                push_result(ST_DONE, -1, cnt, 1'b1);
            end
            default: begin
                // Count aged entries first so the final one carries last
                for (int i = 0; i < DEPTH; i++)
                    if (tv[i] && is_aged(i, now)) n++;
                if (n == 0) push_result(ST_NONE_EXPIRED, -1, '0, 1'b1);
                else begin
                    for (int i = 0; i < DEPTH; i++)
                        if (tv[i] && is_aged(i, now)) begin
                            j++;
                            push_result(ST_EXPIRED, i, '0, j == n);
                            tv[i] = 0;
                        end
                end
            end
        endcase
    endfunction

    // Send one item, idling at random before it
    task automatic send_item(kind_t k, logic [VLAN_W-1:0] v, logic [MAC_W-1:0] m,
                             logic [PB-1:0] p, logic [TB-1:0] now);
        while (tx_idle_en && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k; s_vlan <= v; s_mac <= m; s_port <= p; s_now <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_table(k, v, m, p, now);
    endtask

    // Receiver: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_off <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !rx_idle_en || ($urandom_range(99) >= 37);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        fwd_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected result, status %0d", m_status);
            end else begin
                e = expected_results.pop_front();
                if (m_status !== e.status || m_out_vlan !== e.vlan || m_out_mac !== e.mac ||
                    m_out_port !== e.port || m_out_static !== e.stat ||
                    m_removed_count !== e.cnt || m_last !== e.last) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display({"mismatch exp st=%0d v=%h m=%h p=%0d s=%b c=%0d l=%b",
                                  " | got st=%0d v=%h m=%h p=%0d s=%b c=%0d l=%b"},
                                 e.status, e.vlan, e.mac, e.port, e.stat, e.cnt, e.last,
                                 m_status, m_out_vlan, m_out_mac, m_out_port, m_out_static,
                                 m_removed_count, m_last);
                end
            end
        end
    end

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_ageing(logic [CFG_W-1:0] val);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        age_time = val;
    endtask

    // Learn, move, static override, lookup, removes and ageing edges
    task automatic test_directed();
        send_item(K_LOOKUP, 12'hFFF, 48'hFFFF_FFFF_FFFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(K_EXPIRE, '0, '0, '0, '0);
        send_item(K_LEARN, 12'h000, 48'h0, 6'h0, 32'd0);
        send_item(K_LEARN, 12'hFFF, 48'hFFFF_FFFF_FFFF, 6'h3F, 32'hFFFF_FF00);
        send_item(K_LEARN, 12'h000, 48'h0, 6'h15, 32'd10);
        send_item(K_LEARN, 12'h000, 48'h0, 6'h15, 32'd20);
        send_item(K_LOOKUP, 12'h000, 48'h0, '0, 32'd319);
        send_item(K_LOOKUP, 12'h000, 48'h0, '0, 32'd320);
        send_item(K_LEARN_STATIC, 12'hABC, 48'hAAAA_5555_AAAA, 6'h2A, 32'd5);
        send_item(K_LEARN, 12'hABC, 48'hAAAA_5555_AAAA, 6'h01, 32'd5);
        send_item(K_LOOKUP, 12'hABC, 48'hAAAA_5555_AAAA, '0, 32'hFFFF_FFFF);
        send_item(K_LEARN_STATIC, 12'h000, 48'h0, 6'h2A, 32'd5);
        send_item(K_EXPIRE, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(K_REMOVE, 12'hABC, 48'hAAAA_5555_AAAA, '0, '0);
        send_item(K_REMOVE, 12'hABC, 48'hAAAA_5555_AAAA, '0, '0);
        send_item(K_LEARN, 12'h555, 48'h5555_AAAA_5555, 6'h2A, '0);
        send_item(K_LEARN, 12'h555, 48'h1, 6'h15, '0);
        send_item(K_REM_PORT, '0, '0, 6'h2A, '0);
        send_item(K_REM_VLAN, 12'h555, '0, '0, '0);
        send_item(K_CLEAR, '0, '0, '0, '0);
        // Fill every slot back to back, then one more learn of each flavor answers full
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (int i = 0; i < DEPTH; i++) send_item(K_LEARN, 12'(i), 48'(i), 6'(i), '0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_item(K_LEARN, 12'hFFF, 48'h77, 6'd1, '0);
        send_item(K_LEARN_STATIC, 12'hFFF, 48'h77, 6'd1, '0);
        send_item(K_EXPIRE, '0, '0, '0, 32'd1000);
    endtask

    // Walk the ageing register through its extremes
    task automatic test_ageing_extremes();
        write_ageing(32'd0);
        send_item(K_LEARN, 12'h1, 48'h1, 6'd1, 32'd50);
        send_item(K_LOOKUP, 12'h1, 48'h1, 6'd1, 32'd50);
        write_ageing(32'hFFFF_FFFF);
        send_item(K_LEARN, 12'h2, 48'h2, 6'd2, 32'd1);
        send_item(K_LOOKUP, 12'h2, 48'h2, 6'd2, 32'hFFFF_FFFF);
        send_item(K_EXPIRE, '0, '0, '0, 32'hFFFF_FFFF);
        send_item(K_CLEAR, '0, '0, '0, '0);
        write_ageing(32'd300);
    endtask

    // Random traffic over a small key pool so hits, moves and ageing happen
    task automatic test_random(int count, bit hold);
        logic [TB-1:0] now;
        int r;
        now = $urandom_range(1000);
        for (int i = 0; i < count; i++) begin
            if (hold && i == 2) hold_req++;
            now = now + $urandom_range(60);
            r = $urandom_range(99);
            if (r < 8)
                send_item(kind_t'($urandom_range(7)), 12'($urandom),
                          48'({$urandom, $urandom}), 6'($urandom), $urandom);
            else
                send_item(r < 40 ? K_LEARN : r < 48 ? K_LEARN_STATIC : r < 72 ? K_LOOKUP :
                          r < 82 ? K_REMOVE : r < 86 ? K_REM_PORT : r < 90 ? K_REM_VLAN :
                          r < 92 ? K_CLEAR : K_EXPIRE,
                          12'($urandom_range(3)), 48'($urandom_range(15)) << 40 |
                          48'($urandom_range(7)), 6'($urandom_range(3)), now);
        end
    endtask

    initial begin
        age_time = AGEING_RESET;
        for (int i = 0; i < DEPTH; i++) tv[i] = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_ageing_extremes();
        test_random(6, 1'b1);
        write_ageing(32'd100);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(3, 1'b0);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        write_ageing(32'd40);
        test_random(3, 1'b0);
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
